[rtl/core/rv32_load_store_unit_assert.svh]
// ----------------------------------------------------------------------------
// RV32 load/store unit assertion macros
// Concurrent assertion helpers clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef RV32_LOAD_STORE_UNIT_ASSERT_SVH
`define RV32_LOAD_STORE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define RV32_LSU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define RV32_LSU_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`else

`define RV32_LSU_ASSERT(lbl, prop, msg)

`define RV32_LSU_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

[rtl/core/rv32_lsu_pkg.sv]
// ----------------------------------------------------------------------------
// RV32 load/store unit package
// Shared constants, opcodes and the classified request type.
// ----------------------------------------------------------------------------
package rv32_lsu_pkg;

  localparam int unsigned MEM_BYTES = 65536;
  localparam int unsigned MEM_AW = $clog2(MEM_BYTES);
  localparam logic [31:0] MEM_LIMIT = 32'(MEM_BYTES);

  localparam logic [31:0] CLOCK_ADDR = 32'hDEADBEE0;
  localparam logic [31:0] CONSOLE_ADDR = 32'hDEADBEEE;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_AW = $clog2(QUEUE_DEPTH);

  localparam logic [2:0] OP_LB = 3'd0;
  localparam logic [2:0] OP_LH = 3'd1;
  localparam logic [2:0] OP_LW = 3'd2;
  localparam logic [2:0] OP_LBU = 3'd3;
  localparam logic [2:0] OP_LHU = 3'd4;
  localparam logic [2:0] OP_SB = 3'd5;
  localparam logic [2:0] OP_SH = 3'd6;
  localparam logic [2:0] OP_SW = 3'd7;

  typedef struct packed {
    logic        is_store;
    logic        clock_hit;
    logic        sext_byte;
    logic        sext_half;
    logic [1:0]  last_idx;
    logic [31:0] addr;
    logic [31:0] sval;
    logic [4:0]  rd;
    logic [31:0] now;
  } cmd_t;

endpackage

[rtl/core/rv32_lsu_front.sv]
// ----------------------------------------------------------------------------
// RV32 load/store unit front end
// Accepts requests, forms the effective address and classifies the access.
// ----------------------------------------------------------------------------
module rv32_lsu_front import rv32_lsu_pkg::*; (
  input  logic               start_i,
  output logic               busy_o,
  input  logic [2:0]         opcode_i,
  input  logic [31:0]        base_value_i,
  input  logic signed [11:0] offset_i,
  input  logic [31:0]        store_value_i,
  input  logic [4:0]         dest_reg_i,
  input  logic [31:0]        now_ms_i,
  input  logic               queue_full_i,
  input  logic               clearing_i,
  output logic               push_o,
  output cmd_t               cmd_o
);

  logic [31:0] addr;

  assign addr = base_value_i + {{20{offset_i[11]}}, offset_i};
  assign busy_o = queue_full_i | clearing_i;
  assign push_o = start_i & ~busy_o;

  always_comb begin
    cmd_o.is_store = (opcode_i == OP_SB) || (opcode_i == OP_SH) || (opcode_i == OP_SW);
    cmd_o.clock_hit = (opcode_i == OP_LW) && (addr == CLOCK_ADDR);
    cmd_o.sext_byte = (opcode_i == OP_LB);
    cmd_o.sext_half = (opcode_i == OP_LH);
    cmd_o.addr = addr;
    cmd_o.sval = store_value_i;
    cmd_o.rd = dest_reg_i;
    cmd_o.now = now_ms_i;
    case (opcode_i)
      OP_LB, OP_LBU, OP_SB: cmd_o.last_idx = 2'd0;
      OP_LH, OP_LHU, OP_SH: cmd_o.last_idx = 2'd1;
      OP_LW, OP_SW: cmd_o.last_idx = 2'd3;
      default: cmd_o.last_idx = 2'd0;
    endcase
  end

endmodule

[rtl/core/rv32_lsu_queue.sv]
// ----------------------------------------------------------------------------
// RV32 load/store unit request queue
// Short FIFO of classified requests between the front end and the back end.
// ----------------------------------------------------------------------------
module rv32_lsu_queue import rv32_lsu_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  input  logic pop_i,
  output cmd_t data_o,
  output logic empty_o,
  output logic full_o
);

  cmd_t                slot_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wptr_q, wptr_d;
  logic [QUEUE_AW-1:0] rptr_q, rptr_d;
  logic [QUEUE_AW:0]   cnt_q, cnt_d;

  assign empty_o = (cnt_q == '0);
  assign full_o = (cnt_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign data_o = slot_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= data_i;
    end
  end

endmodule

[rtl/core/rv32_lsu_back.sv]
// ----------------------------------------------------------------------------
// RV32 load/store unit back end
// Byte-serial sequencer over the data memory, with the reset clearing pass.
// ----------------------------------------------------------------------------
module rv32_lsu_back import rv32_lsu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        head_i,
  input  logic        empty_i,
  output logic        pop_o,
  output logic        clearing_o,
  output logic        result_valid_o,
  output logic [31:0] load_result_o,
  output logic [4:0]  write_reg_o,
  output logic        write_enable_o,
  output logic        fault_o,
  output logic        console_valid_o,
  output logic [7:0]  console_char_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CLEAR = 3'd1;
  localparam logic [2:0] ST_LOAD = 3'd2;
  localparam logic [2:0] ST_CAPT = 3'd3;
  localparam logic [2:0] ST_STORE = 3'd4;

  logic [7:0]        mem_q [MEM_BYTES];
  logic [7:0]        rdata_q;

  logic [2:0]        state_q, state_d;
  logic [MEM_AW-1:0] clr_q, clr_d;
  logic [1:0]        idx_q, idx_d;
  logic [31:0]       acc_q, acc_d;
  logic              cv_q, cv_d;
  logic [7:0]        cc_q, cc_d;

  logic [31:0]       byte_a;
  logic              byte_in_mem;
  logic [7:0]        st_byte;
  logic [31:0]       acc_new;
  logic [31:0]       ext_val;

  logic              mem_we;
  logic              mem_re;
  logic [MEM_AW-1:0] mem_waddr;
  logic [7:0]        mem_wdata;

  logic              fin;
  logic [31:0]       fin_res;
  logic              fin_we;
  logic              fin_flt;
  logic              fin_cv;
  logic [7:0]        fin_cc;

  logic              valid_q;
  logic [31:0]       res_q;
  logic [4:0]        rd_q;
  logic              we_q;
  logic              flt_q;
  logic              ocv_q;
  logic [7:0]        occ_q;

  assign byte_a = head_i.addr + 32'(idx_q);
  assign byte_in_mem = (byte_a < MEM_LIMIT);
  assign st_byte = 8'(head_i.sval >> {idx_q, 3'b000});
  assign acc_new = acc_q | (32'(rdata_q) << {idx_q, 3'b000});

  always_comb begin
    ext_val = acc_new;
    if (head_i.sext_byte && acc_new[7]) begin
      ext_val = acc_new | 32'hFFFFFF00;
    end
    if (head_i.sext_half && acc_new[15]) begin
      ext_val = acc_new | 32'hFFFF0000;
    end
  end

  always_comb begin
    state_d = state_q;
    clr_d = clr_q;
    idx_d = idx_q;
    acc_d = acc_q;
    cv_d = cv_q;
    cc_d = cc_q;
    mem_we = 1'b0;
    mem_re = 1'b0;
    mem_waddr = byte_a[MEM_AW-1:0];
    mem_wdata = st_byte;
    fin = 1'b0;
    fin_res = '0;
    fin_we = 1'b0;
    fin_flt = 1'b0;
    fin_cv = 1'b0;
    fin_cc = '0;
    pop_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        if (clr_q == MEM_AW'(MEM_BYTES - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (!empty_i) begin
          acc_d = '0;
          cv_d = 1'b0;
          cc_d = '0;
          if (head_i.clock_hit) begin
            fin = 1'b1;
            fin_res = head_i.now;
            fin_we = 1'b1;
            pop_o = 1'b1;
          end else if (head_i.is_store) begin
            idx_d = head_i.last_idx;
            state_d = ST_STORE;
          end else begin
            idx_d = '0;
            state_d = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        if (!byte_in_mem) begin
          fin = 1'b1;
          fin_flt = 1'b1;
          pop_o = 1'b1;
          state_d = ST_IDLE;
        end else begin
          mem_re = 1'b1;
          state_d = ST_CAPT;
        end
      end
      ST_CAPT: begin
        acc_d = acc_new;
        if (idx_q == head_i.last_idx) begin
          fin = 1'b1;
          fin_res = ext_val;
          fin_we = 1'b1;
          pop_o = 1'b1;
          state_d = ST_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
          state_d = ST_LOAD;
        end
      end
      ST_STORE: begin
        if (byte_a == CONSOLE_ADDR) begin
          cv_d = 1'b1;
          cc_d = st_byte;
        end else if (byte_in_mem) begin
          mem_we = 1'b1;
        end else begin
          fin_flt = 1'b1;
        end
        if (fin_flt || (idx_q == 2'd0)) begin
          fin = 1'b1;
          fin_cv = cv_d;
          fin_cc = cc_d;
          pop_o = 1'b1;
          state_d = ST_IDLE;
        end else begin
          idx_d = idx_q - 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q <= '0;
      idx_q <= '0;
      cv_q <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      idx_q <= idx_d;
      cv_q <= cv_d;
      valid_q <= fin;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    cc_q <= cc_d;
    if (fin) begin
      res_q <= fin_res;
      rd_q <= head_i.rd;
      we_q <= fin_we;
      flt_q <= fin_flt;
      ocv_q <= fin_cv;
      occ_q <= fin_cc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[byte_a[MEM_AW-1:0]];
    end
  end

  assign clearing_o = (state_q == ST_CLEAR);
  assign result_valid_o = valid_q;
  assign load_result_o = res_q;
  assign write_reg_o = rd_q;
  assign write_enable_o = we_q;
  assign fault_o = flt_q;
  assign console_valid_o = ocv_q;
  assign console_char_o = occ_q;

endmodule

[rtl/core/rv32_load_store_unit.sv]
// ----------------------------------------------------------------------------
// RV32 load/store unit
// Byte-addressed little-endian data memory with a clock address and a console
// address. A request is taken when start is high and busy is low; its result
// appears for exactly one cycle with result_valid_o high and cannot be held
// off. After reset the unit clears its 65536-byte memory one byte per cycle,
// keeping busy high until the last byte is cleared. The back end reaches the
// memory through a single byte port. Its idle state takes a request from the
// queue and completes a clock read; a load then passes a read state and a
// capture state per byte, a store writes its bytes from the highest down, and
// a fault ends either one at the failing byte. The result is registered into
// the outputs in the cycle after the request ends. A two-entry queue holds the
// request being carried out and lets one more request be taken meanwhile.
// ----------------------------------------------------------------------------
`include "rv32_load_store_unit_assert.svh"

module rv32_load_store_unit import rv32_lsu_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         opcode_i,
  input  logic [31:0]        base_value_i,
  input  logic signed [11:0] offset_i,
  input  logic [31:0]        store_value_i,
  input  logic [4:0]         dest_reg_i,
  input  logic [31:0]        now_ms_i,
  output logic               result_valid_o,
  output logic [31:0]        load_result_o,
  output logic [4:0]         write_reg_o,
  output logic               write_enable_o,
  output logic               fault_o,
  output logic               console_valid_o,
  output logic [7:0]         console_char_o
);

  logic push;
  cmd_t push_cmd;
  cmd_t head_cmd;
  logic queue_empty;
  logic queue_full;
  logic pop;
  logic clearing;
  logic load_write;

  rv32_lsu_front u_front (
    .start_i       (start),
    .busy_o        (busy),
    .opcode_i      (opcode_i),
    .base_value_i  (base_value_i),
    .offset_i      (offset_i),
    .store_value_i (store_value_i),
    .dest_reg_i    (dest_reg_i),
    .now_ms_i      (now_ms_i),
    .queue_full_i  (queue_full),
    .clearing_i    (clearing),
    .push_o        (push),
    .cmd_o         (push_cmd)
  );

  rv32_lsu_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .pop_i   (pop),
    .data_o  (head_cmd),
    .empty_o (queue_empty),
    .full_o  (queue_full)
  );

  rv32_lsu_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (head_cmd),
    .empty_i         (queue_empty),
    .pop_o           (pop),
    .clearing_o      (clearing),
    .result_valid_o  (result_valid_o),
    .load_result_o   (load_result_o),
    .write_reg_o     (write_reg_o),
    .write_enable_o  (write_enable_o),
    .fault_o         (fault_o),
    .console_valid_o (console_valid_o),
    .console_char_o  (console_char_o)
  );

  assign load_write = result_valid_o && write_enable_o;

  `RV32_LSU_ASSERT(a_clear_busy, clearing |-> busy, "request accepted during memory clear")
  `RV32_LSU_ASSERT_NEVER(a_clear_result, clearing && result_valid_o, "result during memory clear")
  `RV32_LSU_ASSERT(a_load_clean, load_write |-> !(fault_o || console_valid_o), "load with fault")

endmodule
